// ----- rtl/core/lesef_pkg.sv -----
// ----------------------------------------------------------------------------
// lesef_pkg
// Shared types and constants of the eddy-viscosity flux core.
// ----------------------------------------------------------------------------
package lesef_pkg;

   // number format, Q16.16 in 32-bit words
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int NUM_GRAD  = 9;
   localparam int ORD_W     = 3;
   localparam int MC_W      = 16;

   // register file
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_MODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_CONSTANT = 1'b1;
   localparam logic [MC_W-1:0]      MC_RESET           = 16'd11796;

   // square root: 68-bit radicand, 34 root bits, one bit per stage
   localparam int SUM_W  = 68;
   localparam int SQRT_W = 34;
   localparam int SREM_W = SQRT_W + 3;

   // cube root: 66-bit radicand (volume << 32), 22 root bits, one bit per stage
   localparam int CB_W  = 22;
   localparam int CBX_W = 3 * CB_W;
   localparam int CBR_W = 50;

   // order division, two quotient bits per stage
   localparam int DIV_STEPS   = CB_W / 2;
   localparam int ROOT_STAGES = CB_W + 1 + DIV_STEPS;

   // gradient order: xx xy xz yx yy yz zx zy zz
   typedef struct packed {
      logic [NUM_GRAD-1:0][WORD_BITS-1:0] grad;
      logic [WORD_BITS-1:0]               density;
      logic [WORD_BITS-1:0]               length_value;
      logic [ORD_W-1:0]                   order;
   } item_type;

endpackage

// ----- rtl/core/lesef_root_pipe.sv -----
// ----------------------------------------------------------------------------
// lesef_root_pipe
// Pipelined strain-rate square root in parallel with the cube root of the
// element volume, the constant scaling and the division by element order.
// ----------------------------------------------------------------------------
module lesef_root_pipe import lesef_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic [MC_W-1:0]      model_constant,
   input  logic                 in_vld,
   input  item_type             in_item,
   input  logic [SUM_W-1:0]     in_sum,
   output logic                 out_vld,
   output item_type             out_item,
   output logic [SQRT_W-1:0]    out_sqrt,
   output logic [CB_W-1:0]      out_len
);

   typedef struct packed {
      logic [SUM_W-1:0]  x;
      logic [SREM_W-1:0] rem;
      logic [SQRT_W-1:0] y;
   } sq_type;

   typedef struct packed {
      logic [CBX_W-1:0]  x;
      logic [CBR_W-1:0]  rem;
      logic [CB_W-1:0]   y;
      logic [2*CB_W-1:0] y2;
   } cb_type;

   typedef struct packed {
      logic [CB_W-1:0]  q;
      logic [ORD_W-1:0] rem;
   } dv_type;

   // restoring square root, one root bit
   function automatic sq_type sqrt_step(sq_type s);
      sq_type            r;
      logic [SREM_W-1:0] r1;
      logic [SREM_W-1:0] t;
      logic              ge;
      r1 = {s.rem[SREM_W-3:0], s.x[SUM_W-1 -: 2]};
      t  = {{(SREM_W-SQRT_W-2){1'b0}}, s.y, 2'b01};
      ge = (r1 >= t);
      r.x   = {s.x[SUM_W-3:0], 2'b00};
      r.rem = ge ? (r1 - t) : r1;
      r.y   = {s.y[SQRT_W-2:0], ge};
      return r;
   endfunction

   // digit cube root: y^2 tracked alongside y, trial 3(y^2 + y) + 1
   function automatic cb_type cbrt_step(cb_type c);
      cb_type            r;
      logic [CB_W-1:0]   y1;
      logic [2*CB_W-1:0] y21;
      logic [CBR_W-1:0]  r1;
      logic [CBR_W-1:0]  base;
      logic [CBR_W-1:0]  t;
      logic              ge;
      y1   = {c.y[CB_W-2:0], 1'b0};
      y21  = {c.y2[2*CB_W-3:0], 2'b00};
      r1   = {c.rem[CBR_W-4:0], c.x[CBX_W-1 -: 3]};
      base = CBR_W'(y21) + CBR_W'(y1);
      t    = {base[CBR_W-2:0], 1'b0} + base + CBR_W'(1);
      ge   = (r1 >= t);
      r.x   = {c.x[CBX_W-4:0], 3'b000};
      r.rem = ge ? (r1 - t) : r1;
      r.y   = {y1[CB_W-1:1], ge};
      r.y2  = ge ? (y21 + (2*CB_W)'({y1, 1'b0}) + (2*CB_W)'(1)) : y21;
      return r;
   endfunction

   // restoring division by the order, two quotient bits
   function automatic dv_type div_step(dv_type d, logic [ORD_W-1:0] order);
      dv_type           r;
      logic [ORD_W-1:0] dvs;
      logic [ORD_W:0]   part;
      dvs = (order == '0) ? ORD_W'(1) : order;
      r   = d;
      for (int b = 0; b < 2; b++) begin
         part = {r.rem, r.q[CB_W-1]};
         r.q  = {r.q[CB_W-2:0], 1'b0};
         if (part >= {1'b0, dvs}) begin
            part   = part - {1'b0, dvs};
            r.q[0] = 1'b1;
         end
         r.rem = part[ORD_W-1:0];
      end
      return r;
   endfunction

   logic     vld_ff  [ROOT_STAGES];
   item_type item_ff [ROOT_STAGES];
   sq_type   sq_ff   [ROOT_STAGES];
   cb_type   cb_ff   [CB_W];
   dv_type   dv_ff   [DIV_STEPS+1];

   for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
      logic     v_prev;
      item_type it_prev;
      sq_type   sq_prev;

      if (k == 0) begin : g_first
         assign v_prev  = in_vld;
         assign it_prev = in_item;
         assign sq_prev = {in_sum, {(SREM_W+SQRT_W){1'b0}}};
      end else begin : g_next
         assign v_prev  = vld_ff[k-1];
         assign it_prev = item_ff[k-1];
         assign sq_prev = sq_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[k] <= it_prev;
            sq_ff[k]   <= sqrt_step(sq_prev);
         end
      end

      if (k < CB_W) begin : g_cbrt
         cb_type cb_prev;
         if (k == 0) begin : g_cb_first
            assign cb_prev = {{(CBX_W-WORD_BITS-2*FRAC_BITS){1'b0}}, in_item.length_value,
                              {(2*FRAC_BITS){1'b0}}, {(CBR_W+3*CB_W){1'b0}}};
         end else begin : g_cb_next
            assign cb_prev = cb_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               cb_ff[k] <= cbrt_step(cb_prev);
            end
         end
      end else if (k == CB_W) begin : g_scale
         // constant is Q0.16, drop its fraction here
         logic [MC_W+CB_W-1:0] prod;
         assign prod = (MC_W+CB_W)'(model_constant) * (MC_W+CB_W)'(cb_ff[CB_W-1].y);
         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[0] <= {prod[MC_W+CB_W-1:MC_W], {ORD_W{1'b0}}};
            end
         end
      end else begin : g_div
         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[k-CB_W] <= div_step(dv_ff[k-CB_W-1], it_prev.order);
            end
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_STAGES-1];
   assign out_item = item_ff[ROOT_STAGES-1];
   assign out_sqrt = sq_ff[ROOT_STAGES-1].y;
   assign out_len  = dv_ff[DIV_STEPS].q;

endmodule

// ----- rtl/core/les_eddy_viscosity_flux_core.sv -----
// ----------------------------------------------------------------------------
// les_eddy_viscosity_flux_core
// Smagorinsky eddy-viscosity flux for one quadrature point per request.
// ----------------------------------------------------------------------------
// Takes one request per clock while no response is held, and returns one
// response per request, in order. The root section has 34 stages, one for
// each bit of the strain-rate square root, with the cube root of the element
// volume (22 stages), the constant scaling (1) and the division by element
// order (11, two bits each) running alongside. Three input stages and seven
// multiply and saturation stages make up the rest. A stall at the response
// port freezes the whole pipeline; nothing is dropped. All values are Q16.16;
// fluxes clip to the signed 32-bit range and raise saturated. Registers:
// index 0 length_mode, index 1 model_constant (Q0.16).
// ----------------------------------------------------------------------------
module les_eddy_viscosity_flux_core import lesef_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   // register write port
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [MC_W-1:0]             csr_write_data,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [WORD_BITS-1:0] req_grad_xx,
   input  logic signed [WORD_BITS-1:0] req_grad_xy,
   input  logic signed [WORD_BITS-1:0] req_grad_xz,
   input  logic signed [WORD_BITS-1:0] req_grad_yx,
   input  logic signed [WORD_BITS-1:0] req_grad_yy,
   input  logic signed [WORD_BITS-1:0] req_grad_yz,
   input  logic signed [WORD_BITS-1:0] req_grad_zx,
   input  logic signed [WORD_BITS-1:0] req_grad_zy,
   input  logic signed [WORD_BITS-1:0] req_grad_zz,
   input  logic [WORD_BITS-1:0]        req_density,
   input  logic [WORD_BITS-1:0]        req_length_value,
   input  logic [ORD_W-1:0]            req_element_order,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_flux_xx,
   output logic signed [WORD_BITS-1:0] rsp_flux_xy,
   output logic signed [WORD_BITS-1:0] rsp_flux_xz,
   output logic signed [WORD_BITS-1:0] rsp_flux_yx,
   output logic signed [WORD_BITS-1:0] rsp_flux_yy,
   output logic signed [WORD_BITS-1:0] rsp_flux_yz,
   output logic signed [WORD_BITS-1:0] rsp_flux_zx,
   output logic signed [WORD_BITS-1:0] rsp_flux_zy,
   output logic signed [WORD_BITS-1:0] rsp_flux_zz,
   output logic                        rsp_saturated
);

   // datapath widths after each multiply
   localparam int SQD_W = 2 * WORD_BITS;          // diagonal square
   localparam int SQO_W = 2 * WORD_BITS + 2;      // off-diagonal pair square
   localparam int A0_W  = 2 * WORD_BITS;          // L*L
   localparam int A_W   = A0_W - FRAC_BITS;       // L^2 in Q.F
   localparam int PL_W  = 2 * WORD_BITS;
   localparam int PH_W  = A_W;
   localparam int B_W   = A_W + WORD_BITS;        // L^2 * density
   localparam int A2_W  = B_W - FRAC_BITS;
   localparam int NL_W  = WORD_BITS + SQRT_W;
   localparam int NS_W  = NL_W + WORD_BITS;       // times S
   localparam int NU0_W = NS_W - FRAC_BITS;
   localparam int NU_W  = WORD_BITS + FRAC_BITS + 1;
   localparam int FL_W  = 2 * WORD_BITS;
   localparam int FH_W  = NU_W;
   localparam int P_W   = FH_W + WORD_BITS;       // nu * |g|
   localparam int Q_W   = P_W - FRAC_BITS;

   // nu is held here; anything above already saturates every nonzero flux
   localparam logic [NU0_W-1:0] NU_CAP  = NU0_W'(1) << (WORD_BITS + FRAC_BITS);
   localparam logic [Q_W-1:0]   POS_MAX = Q_W'({1'b0, {(WORD_BITS-1){1'b1}}});
   localparam logic [Q_W:0]     NEG_MAG = (Q_W+1)'({1'b1, {(WORD_BITS-1){1'b0}}});
   localparam logic [P_W:0]     RND     = (P_W+1)'({FRAC_BITS{1'b1}});

   typedef struct packed {
      logic                 sat;
      logic [WORD_BITS-1:0] val;
   } flux_type;

   function automatic logic [WORD_BITS-1:0] mag_word(logic [WORD_BITS-1:0] v);
      return v[WORD_BITS-1] ? (WORD_BITS'(0) - v) : v;
   endfunction

   function automatic logic [WORD_BITS:0] mag_pair(logic [WORD_BITS:0] v);
      return v[WORD_BITS] ? ((WORD_BITS+1)'(0) - v) : v;
   endfunction

   // positive terms floor, negative terms floor toward minus infinity
   function automatic flux_type saturate_flux(logic [P_W-1:0] p, logic neg);
      flux_type       f;
      logic [Q_W-1:0] q;
      logic [P_W:0]   pr;
      logic [Q_W:0]   qn;
      q  = p[P_W-1:FRAC_BITS];
      pr = {1'b0, p} + RND;
      qn = pr[P_W:FRAC_BITS];
      f.sat = 1'b0;
      if (!neg) begin
         if (q > POS_MAX) begin
            f.sat = 1'b1;
            f.val = POS_MAX[WORD_BITS-1:0];
         end else begin
            f.val = q[WORD_BITS-1:0];
         end
      end else if (qn > NEG_MAG) begin
         f.sat = 1'b1;
         f.val = NEG_MAG[WORD_BITS-1:0];
      end else begin
         f.val = WORD_BITS'(0) - qn[WORD_BITS-1:0];
      end
      return f;
   endfunction

   // ---------------------------------------------------------------- config
   logic            length_mode_ff;
   logic [MC_W-1:0] model_constant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_mode_ff    <= 1'b0;
         model_constant_ff <= MC_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LENGTH_MODE:    length_mode_ff    <= csr_write_data[0];
            CSR_MODEL_CONSTANT: model_constant_ff <= csr_write_data;
         endcase
      end
   end

   // ------------------------------------------------------------ flow ctrl
   // One enable for every stage: the pipe moves unless a response is held.
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ----------------------------------------------------------- input stage
   item_type req_item;

   assign req_item.grad[0]      = req_grad_xx;
   assign req_item.grad[1]      = req_grad_xy;
   assign req_item.grad[2]      = req_grad_xz;
   assign req_item.grad[3]      = req_grad_yx;
   assign req_item.grad[4]      = req_grad_yy;
   assign req_item.grad[5]      = req_grad_yz;
   assign req_item.grad[6]      = req_grad_zx;
   assign req_item.grad[7]      = req_grad_zy;
   assign req_item.grad[8]      = req_grad_zz;
   assign req_item.density      = req_density;
   assign req_item.length_value = req_length_value;
   assign req_item.order        = req_element_order;

   logic     e_vld_ff;
   item_type e_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_item_ff <= req_item;
      end
   end

   // --------------------------------------------------------- square stage
   // diagonal terms squared; off-diagonal symmetric sums (33 bits) squared
   logic [WORD_BITS-1:0] dmag [3];
   logic [WORD_BITS:0]   omag [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dmag[i] = mag_word(e_item_ff.grad[4*i]);
      end
      omag[0] = mag_pair({e_item_ff.grad[1][WORD_BITS-1], e_item_ff.grad[1]} +
                         {e_item_ff.grad[3][WORD_BITS-1], e_item_ff.grad[3]});
      omag[1] = mag_pair({e_item_ff.grad[2][WORD_BITS-1], e_item_ff.grad[2]} +
                         {e_item_ff.grad[6][WORD_BITS-1], e_item_ff.grad[6]});
      omag[2] = mag_pair({e_item_ff.grad[5][WORD_BITS-1], e_item_ff.grad[5]} +
                         {e_item_ff.grad[7][WORD_BITS-1], e_item_ff.grad[7]});
   end

   logic             q_vld_ff;
   item_type         q_item_ff;
   logic [SQD_W-1:0] q_dsq_ff [3];
   logic [SQO_W-1:0] q_osq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (en) begin
         q_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_item_ff <= e_item_ff;
         for (int i = 0; i < 3; i++) begin
            q_dsq_ff[i] <= SQD_W'(dmag[i]) * SQD_W'(dmag[i]);
            q_osq_ff[i] <= SQO_W'(omag[i]) * SQO_W'(omag[i]);
         end
      end
   end

   // ------------------------------------------------------------ sum stage
   logic             s_vld_ff;
   item_type         s_item_ff;
   logic [SUM_W-1:0] s_sum_ff;
   logic [SUM_W-1:0] sum_in;

   assign sum_in = SUM_W'({q_dsq_ff[0], 1'b0}) + SUM_W'({q_dsq_ff[1], 1'b0}) +
                   SUM_W'({q_dsq_ff[2], 1'b0}) + SUM_W'(q_osq_ff[0]) +
                   SUM_W'(q_osq_ff[1]) + SUM_W'(q_osq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (en) begin
         s_vld_ff <= q_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_item_ff <= q_item_ff;
         s_sum_ff  <= sum_in;
      end
   end

   // ---------------------------------------------------------- root section
   logic              rp_vld;
   item_type          rp_item;
   logic [SQRT_W-1:0] rp_sqrt;
   logic [CB_W-1:0]   rp_len;

   lesef_root_pipe u_root (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .model_constant (model_constant_ff),
      .in_vld         (s_vld_ff),
      .in_item        (s_item_ff),
      .in_sum         (s_sum_ff),
      .out_vld        (rp_vld),
      .out_item       (rp_item),
      .out_sqrt       (rp_sqrt),
      .out_len        (rp_len)
   );

   // --------------------------------------------------------- multiply chain
   // m1: L*L   m2: split L^2*rho   m3: recombine   m4: split *S
   // m5: recombine and cap nu   m6: split nu*|g| per lane
   logic                 len_sel;
   logic [WORD_BITS-1:0] len_val;

   assign len_sel = length_mode_ff;
   assign len_val = len_sel ? rp_item.length_value : WORD_BITS'(rp_len);

   logic              m1_vld_ff, m2_vld_ff, m3_vld_ff, m4_vld_ff, m5_vld_ff, m6_vld_ff;
   item_type          m1_item_ff, m2_item_ff, m3_item_ff, m4_item_ff, m5_item_ff;
   logic [SQRT_W-1:0] m1_s_ff, m2_s_ff, m3_s_ff;
   logic [A0_W-1:0]   m1_a0_ff;
   logic [PL_W-1:0]   m2_pl_ff;
   logic [PH_W-1:0]   m2_ph_ff;
   logic [A2_W-1:0]   m3_a2_ff;
   logic [NL_W-1:0]   m4_nl_ff, m4_nh_ff;
   logic [NU_W-1:0]   m5_nu_ff;
   logic [FL_W-1:0]   m6_fl_ff [NUM_GRAD];
   logic [FH_W-1:0]   m6_fh_ff [NUM_GRAD];
   logic              m6_neg_ff [NUM_GRAD];

   logic [A_W-1:0]   a_q;
   logic [B_W-1:0]   b_sum;
   logic [NS_W-1:0]  n_sum;
   logic [NU0_W-1:0] nu_raw;
   logic [NU_W-1:0]  nu_in;

   assign a_q    = m1_a0_ff[A0_W-1:FRAC_BITS];
   assign b_sum  = B_W'(m2_pl_ff) + {m2_ph_ff, {WORD_BITS{1'b0}}};
   assign n_sum  = NS_W'(m4_nl_ff) + {m4_nh_ff, {WORD_BITS{1'b0}}};
   assign nu_raw = n_sum[NS_W-1:FRAC_BITS];
   assign nu_in  = (nu_raw > NU_CAP) ? NU_CAP[NU_W-1:0] : nu_raw[NU_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
         m4_vld_ff <= 1'b0;
         m5_vld_ff <= 1'b0;
         m6_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= rp_vld;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
         m4_vld_ff <= m3_vld_ff;
         m5_vld_ff <= m4_vld_ff;
         m6_vld_ff <= m5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_item_ff <= rp_item;
         m1_s_ff    <= rp_sqrt;
         m1_a0_ff   <= A0_W'(len_val) * A0_W'(len_val);

         m2_item_ff <= m1_item_ff;
         m2_s_ff    <= m1_s_ff;
         m2_pl_ff   <= PL_W'(a_q[WORD_BITS-1:0]) * PL_W'(m1_item_ff.density);
         m2_ph_ff   <= PH_W'(a_q[A_W-1:WORD_BITS]) * PH_W'(m1_item_ff.density);

         m3_item_ff <= m2_item_ff;
         m3_s_ff    <= m2_s_ff;
         m3_a2_ff   <= b_sum[B_W-1:FRAC_BITS];

         m4_item_ff <= m3_item_ff;
         m4_nl_ff   <= NL_W'(m3_a2_ff[WORD_BITS-1:0]) * NL_W'(m3_s_ff);
         m4_nh_ff   <= NL_W'(m3_a2_ff[A2_W-1:WORD_BITS]) * NL_W'(m3_s_ff);

         m5_item_ff <= m4_item_ff;
         m5_nu_ff   <= nu_in;

         for (int i = 0; i < NUM_GRAD; i++) begin
            m6_fl_ff[i]  <= FL_W'(m5_nu_ff[WORD_BITS-1:0]) *
                            FL_W'(mag_word(m5_item_ff.grad[i]));
            m6_fh_ff[i]  <= FH_W'(m5_nu_ff[NU_W-1:WORD_BITS]) *
                            FH_W'(mag_word(m5_item_ff.grad[i]));
            m6_neg_ff[i] <= m5_item_ff.grad[i][WORD_BITS-1];
         end
      end
   end

   // ----------------------------------------------------- output register
   flux_type flux_in [NUM_GRAD];
   logic     sat_in;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < NUM_GRAD; i++) begin
         flux_in[i] = saturate_flux(P_W'(m6_fl_ff[i]) + {m6_fh_ff[i], {WORD_BITS{1'b0}}},
                                    m6_neg_ff[i]);
         sat_in     = sat_in | flux_in[i].sat;
      end
   end

   logic [WORD_BITS-1:0] rsp_flux_ff [NUM_GRAD];
   logic                 rsp_saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_GRAD; i++) begin
            rsp_flux_ff[i] <= flux_in[i].val;
         end
         rsp_saturated_ff <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_flux_xx   = rsp_flux_ff[0];
   assign rsp_flux_xy   = rsp_flux_ff[1];
   assign rsp_flux_xz   = rsp_flux_ff[2];
   assign rsp_flux_yx   = rsp_flux_ff[3];
   assign rsp_flux_yy   = rsp_flux_ff[4];
   assign rsp_flux_yz   = rsp_flux_ff[5];
   assign rsp_flux_zx   = rsp_flux_ff[6];
   assign rsp_flux_zy   = rsp_flux_ff[7];
   assign rsp_flux_zz   = rsp_flux_ff[8];
   assign rsp_saturated = rsp_saturated_ff;

   // ------------------------------------------------------------ assertions
   logic flux_at_rail;

   always_comb begin
      flux_at_rail = 1'b0;
      for (int i = 0; i < NUM_GRAD; i++) begin
         flux_at_rail = flux_at_rail ||
                        (rsp_flux_ff[i] == POS_MAX[WORD_BITS-1:0]) ||
                        (rsp_flux_ff[i] == NEG_MAG[WORD_BITS-1:0]);
      end
   end

   // an empty output register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request blocked with empty output");

   // the saturated flag comes only with a flux pinned at a rail
   a_sat_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_saturated_ff) |-> flux_at_rail)
      else $error("saturated flag without clipped flux");

   // viscosity never exceeds its ceiling
   a_nu_capped: assert property (@(posedge clock) disable iff (reset)
      m5_vld_ff |-> (NU0_W'(m5_nu_ff) <= NU_CAP))
      else $error("eddy viscosity above ceiling");

   // a held response freezes the last multiply stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(m6_vld_ff) && $stable(m5_nu_ff))
      else $error("pipeline moved during stall");

endmodule
